[rtl/assert_macros.svh]
// Assertion macros shared by the modular exponentiation RTL.
// Each macro expects a signal named clk in the using module; MEXP_ASSERT also expects rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge once reset has been released.
`define MEXP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define MEXP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/mexp_pkg.sv]
// Shared constants for the modular exponentiation block.
// No dependencies; imported by the top level and by mexp_mul.
package mexp_pkg;

  localparam int FIELD_BITS    = 64;                // width of every stream field
  localparam int DEF_WORD_BITS = 64;                // default working width
  localparam int IN_DATA_BITS  = 3 * FIELD_BITS;    // base, power, divisor

endpackage

[rtl/modular_exponentiation_64.sv]
// Modular exponentiation base^power mod divisor, right-to-left square and multiply.
// Two bit-serial multipliers do the work, one multiplier bit per cycle; a zero divisor skips them.
// One request is worked at a time; the next can be accepted in the cycle after a result is loaded,
// even while that result waits to be taken.
// Synchronous active-low reset empties the output register and returns to idle.
`include "assert_macros.svh"

module modular_exponentiation_64
  import mexp_pkg::*;
#(
  parameter int WORD_BITS = DEF_WORD_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [IN_DATA_BITS-1:0] in_tdata,   // base_value [63:0], power [127:64], divisor [191:128]
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [FIELD_BITS-1:0]   out_tdata,  // residue [63:0]
  output logic                    out_tuser   // zero_modulus [0]
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RED,
    S_EXP,
    S_STEP,
    S_OUT
  } state_t;

  state_t               state_r, state_nxt;
  logic [WORD_BITS-1:0] b_r, b_nxt;
  logic [WORD_BITS-1:0] e_r, e_nxt;
  logic [WORD_BITS-1:0] m_r, m_nxt;
  logic [WORD_BITS-1:0] acc_r, acc_nxt;
  logic                 err_r, err_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [WORD_BITS-1:0] residue_r, residue_nxt;
  logic                 zm_r, zm_nxt;

  logic [WORD_BITS-1:0] in_base, in_power, in_div;
  logic                 start0, start1;
  logic [WORD_BITS-1:0] k0, v0, m0;
  logic                 busy0, busy1;
  logic [WORD_BITS-1:0] prod0, prod1;

  assign in_base  = in_tdata[WORD_BITS-1:0];
  assign in_power = in_tdata[FIELD_BITS +: WORD_BITS];
  assign in_div   = in_tdata[2*FIELD_BITS +: WORD_BITS];

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    b_nxt         = b_r;
    e_nxt         = e_r;
    m_nxt         = m_r;
    acc_nxt       = acc_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r;
    residue_nxt   = residue_r;
    zm_nxt        = zm_r;
    start0        = 1'b0;
    start1        = 1'b0;
    k0            = acc_r;
    v0            = b_r;
    m0            = m_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          e_nxt   = in_power;
          m_nxt   = in_div;
          acc_nxt = WORD_BITS'(1);
          if (in_div == '0) begin
            acc_nxt   = '0;
            err_nxt   = 1'b1;
            state_nxt = S_OUT;
          end else begin
            // Reduce the base: base * (1 mod m) through the multiplier.
            err_nxt   = 1'b0;
            start0    = 1'b1;
            k0        = in_base;
            v0        = (in_div == WORD_BITS'(1)) ? '0 : WORD_BITS'(1);
            m0        = in_div;
            state_nxt = S_RED;
          end
        end
      end
      S_RED: begin
        if (!busy0) begin
          b_nxt     = prod0;
          state_nxt = (e_r == '0) ? S_OUT : S_EXP;
        end
      end
      S_EXP: begin
        start0    = e_r[0];
        start1    = 1'b1;
        state_nxt = S_STEP;
      end
      S_STEP: begin
        if (!busy0 && !busy1) begin
          if (e_r[0]) begin
            acc_nxt = prod0;
          end
          b_nxt     = prod1;
          e_nxt     = e_r >> 1;
          state_nxt = ((e_r >> 1) == '0) ? S_OUT : S_EXP;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          residue_nxt   = acc_r;
          zm_nxt        = err_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    b_r       <= b_nxt;
    e_r       <= e_nxt;
    m_r       <= m_nxt;
    acc_r     <= acc_nxt;
    err_r     <= err_nxt;
    residue_r <= residue_nxt;
    zm_r      <= zm_nxt;
  end

  // Unit 0 reduces the base, then multiplies the accumulator; unit 1 squares.
  mexp_mul #(
    .WORD_BITS(WORD_BITS)
  ) u_mul_acc (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start0),
    .k_in   (k0),
    .v_in   (v0),
    .m_in   (m0),
    .busy   (busy0),
    .product(prod0)
  );

  mexp_mul #(
    .WORD_BITS(WORD_BITS)
  ) u_mul_sq (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start1),
    .k_in   (b_r),
    .v_in   (b_r),
    .m_in   (m_r),
    .busy   (busy1),
    .product(prod1)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = FIELD_BITS'(residue_r);
  assign out_tuser  = zm_r;

  `MEXP_ASSERT(a_error_gives_zero, (out_tvalid && out_tuser) |-> (out_tdata == '0), "error not zero")
  `MEXP_ASSERT(a_step_nonzero_mod, (state_r == S_STEP) |-> (m_r != '0), "step with zero modulus")
  `MEXP_ASSERT(a_units_idle_at_rest, (state_r == S_IDLE) |-> (!busy0 && !busy1), "unit busy in idle")

endmodule

[rtl/mexp_mul.sv]
// Bit-serial modular multiplier: k * v mod m by shift and add, one bit of k per cycle.
// Requires v < m on start. Depends on mexp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mexp_mul
  import mexp_pkg::*;
#(
  parameter int WORD_BITS = DEF_WORD_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [WORD_BITS-1:0] k_in,
  input  logic [WORD_BITS-1:0] v_in,
  input  logic [WORD_BITS-1:0] m_in,
  output logic                 busy,
  output logic [WORD_BITS-1:0] product
);

  logic                 busy_r, busy_nxt;
  logic [WORD_BITS-1:0] k_r, k_nxt;
  logic [WORD_BITS-1:0] v_r, v_nxt;
  logic [WORD_BITS-1:0] m_r, m_nxt;
  logic [WORD_BITS-1:0] acc_r, acc_nxt;
  logic [WORD_BITS-1:0] gap;

  // Both the accumulate and the doubling add v, so they share m - v.
  assign gap = m_r - v_r;

  always_comb begin
    busy_nxt = busy_r;
    k_nxt    = k_r;
    v_nxt    = v_r;
    m_nxt    = m_r;
    acc_nxt  = acc_r;
    if (start) begin
      busy_nxt = 1'b1;
      k_nxt    = k_in;
      v_nxt    = v_in;
      m_nxt    = m_in;
      acc_nxt  = '0;
    end else if (busy_r) begin
      if (k_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        if (k_r[0]) begin
          acc_nxt = (acc_r >= gap) ? (acc_r - gap) : (acc_r + v_r);
        end
        v_nxt = (v_r >= gap) ? (v_r - gap) : (v_r << 1);
        k_nxt = k_r >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    k_r   <= k_nxt;
    v_r   <= v_nxt;
    m_r   <= m_nxt;
    acc_r <= acc_nxt;
  end

  assign busy    = busy_r;
  assign product = acc_r;

  `MEXP_ASSERT(a_operands_reduced, busy_r |-> (v_r < m_r && acc_r < m_r), "operand not reduced")
  `MEXP_ASSERT(a_stops_when_drained, (busy_r && !start && k_r == '0) |=> !busy_r, "unit did not stop")
  `MEXP_ASSERT(a_modulus_nonzero, busy_r |-> (m_r != '0), "zero modulus in unit")

endmodule
